// ===== rtl/core/nsd_pkg.sv =====
package nsd_pkg;

  localparam int WORD_W      = 16;
  localparam int COUNT_W     = 4;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCOUNT_W    = 2;

  typedef enum logic [0:0] {
    REG_FIRST_SUBKEY  = 1'b0,
    REG_SECOND_SUBKEY = 1'b1
  } reg_index_t;

  // old chain value and new chain value of one word, handed to the back end
  typedef struct packed {
    logic [WORD_W-1:0] old_chain;
    logic [WORD_W-1:0] new_chain;
  } nsd_entry_t;

  localparam logic [3:0] SBOX [4][16] = '{
    '{4'd9, 4'd8, 4'd2, 4'd11, 4'd1, 4'd14, 4'd5, 4'd15,
      4'd12, 4'd6, 4'd0, 4'd3, 4'd7, 4'd13, 4'd10, 4'd4},
    '{4'd2, 4'd10, 4'd0, 4'd15, 4'd14, 4'd1, 4'd11, 4'd3,
      4'd7, 4'd12, 4'd13, 4'd8, 4'd4, 4'd9, 4'd5, 4'd6},
    '{4'd4, 4'd11, 4'd3, 4'd8, 4'd7, 4'd2, 4'd15, 4'd13,
      4'd1, 4'd5, 4'd14, 4'd9, 4'd6, 4'd12, 4'd0, 4'd10},
    '{4'd1, 4'd13, 4'd8, 4'd2, 4'd0, 4'd5, 4'd6, 4'd14,
      4'd4, 4'd11, 4'd15, 4'd10, 4'd12, 4'd3, 4'd7, 4'd9}
  };

  // running nibble starts at the top nibble; bit b of step i lands in
  // output nibble (i - b) mod 4
  function automatic logic [WORD_W-1:0] spn_round(logic [WORD_W-1:0] x);
    logic [3:0] acc;
    logic [3:0] outn [4];
    logic [1:0] idx;
    logic [WORD_W-1:0] r;
    acc = x[15:12];
    for (int n = 0; n < 4; n++) begin
      outn[n] = 4'd0;
    end
    for (int i = 0; i < 4; i++) begin
      acc = acc ^ SBOX[i][x[4*i +: 4]];
      for (int b = 0; b < 4; b++) begin
        idx = 2'(i - b);
        outn[idx][b] = outn[idx][b] | acc[b];
      end
    end
    r = {outn[3], outn[2], outn[1], outn[0]};
    return r;
  endfunction

  function automatic logic [WORD_W-1:0] keyed_round(logic [WORD_W-1:0] x,
                                                    logic [WORD_W-1:0] k);
    return spn_round(x ^ k) ^ k;
  endfunction

endpackage

// ===== rtl/core/nsd_front.sv =====
module nsd_front #(
  parameter int BLOCK_WORDS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       restart,
  input  logic [nsd_pkg::WORD_W-1:0] cipher_word,
  input  logic [nsd_pkg::WORD_W-1:0] first_subkey,
  input  logic                       q_full,
  output logic                       q_push,
  output nsd_pkg::nsd_entry_t        q_entry
);
  import nsd_pkg::*;

  localparam logic [COUNT_W:0] BLOCK_END = (COUNT_W+1)'(BLOCK_WORDS);

  logic [WORD_W-1:0]  chain_value, chain_value_next;
  logic [COUNT_W-1:0] word_count, word_count_next;
  logic [WORD_W-1:0]  chain_in;
  logic [COUNT_W-1:0] count_in;
  logic [WORD_W-1:0]  new_chain;
  logic [COUNT_W:0]   count_inc;

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;

  always_comb begin
    chain_in  = restart ? '0 : chain_value;
    count_in  = restart ? '0 : word_count;
    new_chain = keyed_round(cipher_word ^ chain_in, first_subkey);
    count_inc = {1'b0, count_in} + (COUNT_W+1)'(1);
    q_entry.old_chain = chain_in;
    q_entry.new_chain = new_chain;
    if (count_inc == BLOCK_END) begin
      chain_value_next = '0;
      word_count_next  = '0;
    end else begin
      chain_value_next = new_chain;
      word_count_next  = count_inc[COUNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chain_value <= '0;
      word_count  <= '0;
    end else if (q_push) begin
      chain_value <= chain_value_next;
      word_count  <= word_count_next;
    end
  end

endmodule

// ===== rtl/core/nsd_queue.sv =====
module nsd_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  nsd_pkg::nsd_entry_t push_entry,
  output logic                full,
  output logic                head_valid,
  input  logic                pop,
  output nsd_pkg::nsd_entry_t head_entry
);
  import nsd_pkg::*;

  nsd_entry_t          entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr, rd_ptr;
  logic [QCOUNT_W-1:0] fill;

  assign full       = (fill == QCOUNT_W'(QUEUE_DEPTH));
  assign head_valid = (fill != '0);
  assign head_entry = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      unique case ({push, pop})
        2'b10:   fill <= fill + QCOUNT_W'(1);
        2'b01:   fill <= fill - QCOUNT_W'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ===== rtl/core/nsd_back.sv =====
module nsd_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       head_valid,
  input  nsd_pkg::nsd_entry_t        head_entry,
  output logic                       pop,
  input  logic [nsd_pkg::WORD_W-1:0] second_subkey,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [nsd_pkg::WORD_W-1:0] plain_word
);
  import nsd_pkg::*;

  logic              take;
  logic [WORD_W-1:0] plain_next;

  assign take = !out_valid || out_ready;
  assign pop  = head_valid && take;

  always_comb begin
    plain_next = head_entry.old_chain ^ keyed_round(head_entry.new_chain, second_subkey);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= head_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      plain_word <= plain_next;
    end
  end

endmodule

// ===== rtl/core/nibble_spn_stream_decrypt.sv =====
// channel   dir  tdata            tuser      notes
// s_*       in   [15:0] cipher    [0] restart one cipher word per beat
// m_*       out  [15:0] plain     -          one plain word per cipher word
// cfg_*     in   [15:0] subkey    -          index 0 first, 1 second subkey
//
// One word per cycle sustained if m_tready is high; the chaining register
// loop holds one keyed S-box round. m_tvalid is registered after the queue.
// Reset clears chain value, word counter, subkeys, queue and output valid.
// A two-entry queue parts the front from the output stage, so input keeps
// flowing while one result waits on m_tready.
module nibble_spn_stream_decrypt #(
  parameter int BLOCK_WORDS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [nsd_pkg::WORD_W-1:0] s_tdata,   // [15:0] cipher_word
  input  logic                       s_tuser,   // [0] restart
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [nsd_pkg::WORD_W-1:0] m_tdata,   // [15:0] plain_word
  input  logic                       cfg_we,
  input  logic [0:0]                 cfg_index,
  input  logic [nsd_pkg::WORD_W-1:0] cfg_data
);
  import nsd_pkg::*;

  logic [WORD_W-1:0] first_subkey, second_subkey;
  logic              q_full, q_push, q_pop, q_head_valid;
  nsd_entry_t        q_entry, q_head;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_subkey  <= '0;
      second_subkey <= '0;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_FIRST_SUBKEY:  first_subkey  <= cfg_data;
        REG_SECOND_SUBKEY: second_subkey <= cfg_data;
        default: ;
      endcase
    end
  end

  nsd_front #(
    .BLOCK_WORDS(BLOCK_WORDS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .restart      (s_tuser),
    .cipher_word  (s_tdata),
    .first_subkey (first_subkey),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_entry      (q_entry)
  );

  nsd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_entry),
    .full       (q_full),
    .head_valid (q_head_valid),
    .pop        (q_pop),
    .head_entry (q_head)
  );

  nsd_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head_valid    (q_head_valid),
    .head_entry    (q_head),
    .pop           (q_pop),
    .second_subkey (second_subkey),
    .out_valid     (m_tvalid),
    .out_ready     (m_tready),
    .plain_word    (m_tdata)
  );

endmodule

// ===== tb/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import nsd_pkg::*;

  localparam int BLOCK_WORDS    = 16;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int RANDOM_WORDS   = 1600;

  localparam logic [3:0] SUBST [4][16] = '{
    '{4'h9, 4'h8, 4'h2, 4'hb, 4'h1, 4'he, 4'h5, 4'hf,
      4'hc, 4'h6, 4'h0, 4'h3, 4'h7, 4'hd, 4'ha, 4'h4},
    '{4'h2, 4'ha, 4'h0, 4'hf, 4'he, 4'h1, 4'hb, 4'h3,
      4'h7, 4'hc, 4'hd, 4'h8, 4'h4, 4'h9, 4'h5, 4'h6},
    '{4'h4, 4'hb, 4'h3, 4'h8, 4'h7, 4'h2, 4'hf, 4'hd,
      4'h1, 4'h5, 4'he, 4'h9, 4'h6, 4'hc, 4'h0, 4'ha},
    '{4'h1, 4'hd, 4'h8, 4'h2, 4'h0, 4'h5, 4'h6, 4'he,
      4'h4, 4'hb, 4'hf, 4'ha, 4'hc, 4'h3, 4'h7, 4'h9}
  };

  typedef struct {
    logic              restart;
    logic [WORD_W-1:0] cipher;
  } cipher_item_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [WORD_W-1:0] s_tdata = '0;
  logic              s_tuser = 1'b0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [WORD_W-1:0] m_tdata;
  logic              cfg_we = 1'b0;
  logic [0:0]        cfg_index = REG_FIRST_SUBKEY;
  logic [WORD_W-1:0] cfg_data = '0;

  nibble_spn_stream_decrypt #(
    .BLOCK_WORDS(BLOCK_WORDS)
  ) uut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  cipher_item_t      cipher_feed [$];
  logic [WORD_W-1:0] plain_due [$];

  // predictor state
  logic [WORD_W-1:0]  chain_key = '0;
  logic [WORD_W-1:0]  out_key = '0;
  logic [WORD_W-1:0]  chain_reg = '0;
  logic [COUNT_W-1:0] block_pos = '0;

  int  tx_idle_pct = 0;
  int  rx_idle_pct = 0;
  int  items_queued = 0;
  int  items_taken = 0;
  int  results_seen = 0;
  int  fail_count = 0;
  int  key_settings = 0;
  logic word_taken = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [WORD_W-1:0] nibble_round(logic [WORD_W-1:0] x);
    logic [3:0]        run;
    logic [WORD_W-1:0] r;
    run = x[15:12];
    r = '0;
    for (int i = 0; i < 4; i++) begin
      run = run ^ SUBST[i][x[4*i +: 4]];
      // bit b of the running nibble goes to output nibble (i - b) mod 4
      for (int b = 0; b < 4; b++) begin
        r[4*((i - b) & 3) + b] = r[4*((i - b) & 3) + b] | run[b];
      end
    end
    return r;
  endfunction

  function automatic logic [WORD_W-1:0] keyed_nibble_round(logic [WORD_W-1:0] x,
                                                           logic [WORD_W-1:0] k);
    return nibble_round(x ^ k) ^ k;
  endfunction

  function automatic logic [WORD_W-1:0] predict_plain(logic restart,
                                                      logic [WORD_W-1:0] cipher);
    logic [WORD_W-1:0] old_chain;
    logic [4:0]        next_pos;
    if (restart) begin
      chain_reg = '0;
      block_pos = '0;
    end
    old_chain = chain_reg;
    chain_reg = keyed_nibble_round(cipher ^ chain_reg, chain_key);
    next_pos = {1'b0, block_pos} + 5'd1;
    if (next_pos == 5'(BLOCK_WORDS)) begin
      block_pos = '0;
      // plain word uses the new chain value before the block-end clear
      predict_plain = old_chain ^ keyed_nibble_round(chain_reg, out_key);
      chain_reg = '0;
    end else begin
      block_pos = next_pos[COUNT_W-1:0];
      predict_plain = old_chain ^ keyed_nibble_round(chain_reg, out_key);
    end
  endfunction

  // sender and receiver, both driven on the falling edge
  always @(negedge clk) begin : drive
    cipher_item_t item;
    if (rst) begin
      s_tvalid <= 1'b0;
      m_tready <= 1'b0;
    end else begin
      if (!s_tvalid || word_taken) begin
        if (cipher_feed.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          item = cipher_feed.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= item.cipher;
          s_tuser  <= item.restart;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
      m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin : watch
    logic [WORD_W-1:0] want;
    if (rst) begin
      word_taken <= 1'b0;
    end else begin
      word_taken <= s_tvalid && s_tready;
      if (s_tvalid && s_tready) begin
        plain_due.push_back(predict_plain(s_tuser, s_tdata));
        items_taken++;
      end
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (plain_due.size() == 0) begin
          $error("plain_word: expected none, got %h", m_tdata);
          fail_count++;
        end else begin
          want = plain_due.pop_front();
          if (m_tdata !== want) begin
            $error("plain_word: expected %h, got %h", want, m_tdata);
            fail_count++;
          end
        end
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || rst) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $error("no word moved for %0d cycles", WATCHDOG_LIMIT);
    $display("Mismatches found");
    $finish;
  end

  task automatic write_key(reg_index_t idx, logic [WORD_W-1:0] value);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_FIRST_SUBKEY: begin
        chain_key = value;
      end
      REG_SECOND_SUBKEY: begin
        out_key = value;
      end
      default: begin
      end
    endcase
  endtask

  task automatic set_keys(logic [WORD_W-1:0] first, logic [WORD_W-1:0] second);
    write_key(REG_FIRST_SUBKEY, first);
    write_key(REG_SECOND_SUBKEY, second);
    key_settings++;
  endtask

  task automatic queue_word(logic restart, logic [WORD_W-1:0] cipher);
    cipher_item_t item;
    item.restart = restart;
    item.cipher  = cipher;
    cipher_feed.push_back(item);
    items_queued++;
  endtask

  // stimulus holds off until every queued word is taken and its result seen
  task automatic drain;
    @(negedge clk);
    while (items_taken != items_queued || results_seen != items_taken) begin
      @(negedge clk);
    end
    repeat (4) @(negedge clk);
  endtask

  // runs open with a restart most of the time; long runs cross block ends
  task automatic queue_stream(int count);
    int run_len;
    int made;
    made = 0;
    while (made < count) begin
      run_len = $urandom_range(40, 1);
      for (int k = 0; k < run_len; k++) begin
        if (k == 0) begin
          queue_word($urandom_range(9) != 0, 16'($urandom_range(65535)));
        end else begin
          queue_word($urandom_range(29) == 0, 16'($urandom_range(65535)));
        end
        made++;
      end
    end
  endtask

  initial begin : stimulus
    logic [WORD_W-1:0] edge_words [15];
    edge_words = '{16'hffff, 16'h0001, 16'h8000, 16'haaaa, 16'h5555, 16'h000f,
                   16'hf000, 16'h00f0, 16'h0f00, 16'h7fff, 16'hfffe, 16'h1234,
                   16'hedcb, 16'h0000, 16'hc3a5};
    repeat (5) @(negedge clk);
    rst = 1'b0;

    // directed: keys at zero, one full block, then restart cases
    set_keys(16'h0000, 16'h0000);
    queue_word(1'b1, 16'h0000);
    foreach (edge_words[i]) queue_word(1'b0, edge_words[i]);
    queue_word(1'b0, 16'hffff);          // first word after block-end clear
    queue_word(1'b0, 16'h4321);
    queue_word(1'b1, 16'hffff);          // restart mid-block
    queue_word(1'b1, 16'h0000);          // back-to-back restarts
    queue_word(1'b0, 16'h9e37);
    tx_idle_pct = 27;
    rx_idle_pct = 65;
    drain();

    set_keys(16'hffff, 16'hffff);
    queue_word(1'b1, 16'h0000);
    queue_word(1'b0, 16'hffff);
    queue_stream(RANDOM_WORDS / 3);
    drain();

    // receiver-side pressure swaps over; sender pauses half way to empty out
    tx_idle_pct = 65;
    rx_idle_pct = 27;
    set_keys(16'($urandom_range(65535)), 16'($urandom_range(65535)));
    queue_stream(RANDOM_WORDS / 6);
    drain();
    set_keys(16'hffff, 16'h0000);
    queue_stream(RANDOM_WORDS / 6);
    drain();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    set_keys(16'h0000, 16'hffff);
    queue_stream(RANDOM_WORDS / 6);
    drain();
    set_keys(16'($urandom_range(65535)), 16'($urandom_range(65535)));
    queue_stream(RANDOM_WORDS / 6);
    drain();
    repeat (8) @(negedge clk);

    if (plain_due.size() != 0) begin
      $error("plain_word: %0d expected words never arrived", plain_due.size());
      fail_count++;
    end
    $display("Decrypted %0d cipher words under %0d subkey pairs,", items_taken, key_settings);
    $display("with stalls on each side in turn and at full rate; %0d errors.", fail_count);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/nsd_pkg.sv
rtl/core/nsd_front.sv
rtl/core/nsd_queue.sv
rtl/core/nsd_back.sv
rtl/core/nibble_spn_stream_decrypt.sv
tb/testbench.sv
